[hdl/rcoa_pkg.sv]
`default_nettype none

package rcoa_pkg;

  localparam int MAX_CORE = 8192;
  localparam int DATA_W   = $clog2(MAX_CORE);
  localparam int CS_W     = DATA_W + 1;
  localparam int CNT_W    = $clog2(DATA_W);
  localparam int MODE_W   = 3;

  localparam logic [CS_W-1:0]  CS_RESET = CS_W'(8000);
  localparam logic [CS_W-1:0]  CS_MIN   = CS_W'(2);
  localparam logic [CS_W-1:0]  CS_MAX   = CS_W'(MAX_CORE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  // input item kinds, carried on tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // operand addressing modes
  localparam logic [MODE_W-1:0] MODE_IMM    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DIR    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BIND   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AIND   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BPRE   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_APRE   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_BPOST  = 3'd6;
  localparam logic [MODE_W-1:0] MODE_APOST  = 3'd7;

  // stream payload layout
  localparam int IN_ADDR_LSB = 0;
  localparam int IN_PC_LSB   = IN_ADDR_LSB + DATA_W;
  localparam int IN_AF_LSB   = IN_PC_LSB + DATA_W;
  localparam int IN_BF_LSB   = IN_AF_LSB + DATA_W;
  localparam int IN_AM_LSB   = IN_BF_LSB + DATA_W;
  localparam int IN_BM_LSB   = IN_AM_LSB + MODE_W;
  localparam int IN_USED_W   = IN_BM_LSB + MODE_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W  = 4 * DATA_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  typedef struct packed {
    logic [DATA_W-1:0] addr;
    logic              we_a;
    logic              we_b;
    logic [DATA_W-1:0] wdata_a;
    logic [DATA_W-1:0] wdata_b;
  } core_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } core_rsp_t;

endpackage

`default_nettype wire

[hdl/rcoa_modadd.sv]
`default_nettype none

// Modular adder: both operands together stay below twice the modulus.
module rcoa_modadd (
  input  wire logic [rcoa_pkg::CS_W-1:0]   x,
  input  wire logic [rcoa_pkg::DATA_W-1:0] y,
  input  wire logic [rcoa_pkg::CS_W-1:0]   cs,
  output logic      [rcoa_pkg::DATA_W-1:0] sum
);

  logic [rcoa_pkg::CS_W:0] raw;
  logic [rcoa_pkg::CS_W:0] diff;

  always_comb begin
    raw  = {1'b0, x} + {2'b00, y};
    diff = raw - {1'b0, cs};
    if (raw >= {1'b0, cs}) begin
      sum = diff[rcoa_pkg::DATA_W-1:0];
    end else begin
      sum = raw[rcoa_pkg::DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/rcoa_core.sv]
`default_nettype none

// Core cell store: A and B field arrays on one shared address, registered read.
module rcoa_core (
  input  wire logic                clk,
  input  wire rcoa_pkg::core_req_t req,
  output rcoa_pkg::core_rsp_t      rsp
);

  logic [rcoa_pkg::DATA_W-1:0] mem_a [rcoa_pkg::MAX_CORE];
  logic [rcoa_pkg::DATA_W-1:0] mem_b [rcoa_pkg::MAX_CORE];

  always_ff @(posedge clk) begin
    if (req.we_a) begin
      mem_a[req.addr] <= req.wdata_a;
    end
    if (req.we_b) begin
      mem_b[req.addr] <= req.wdata_b;
    end
    rsp.a <= mem_a[req.addr];
    rsp.b <= mem_b[req.addr];
  end

endmodule

`default_nettype wire

[hdl/rcoa_seq.sv]
`default_nettype none

// Sequencer around the shared modular adder.
module rcoa_seq (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [rcoa_pkg::CS_W-1:0]             cs,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [rcoa_pkg::IN_TDATA_W-1:0]       in_data,
  input  wire logic                                  in_op,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic      [rcoa_pkg::OUT_TDATA_W-1:0]      out_data,
  output rcoa_pkg::core_req_t                        core_req,
  input  wire rcoa_pkg::core_rsp_t                   core_rsp
);

  localparam int DW = rcoa_pkg::DATA_W;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MOD   = 9'b000000010,
    ST_CELL  = 9'b000000100,
    ST_FETCH = 9'b000001000,
    ST_DEC   = 9'b000010000,
    ST_OFFS  = 9'b000100000,
    ST_INC   = 9'b001000000,
    ST_WRITE = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    RED_FIRST,
    RED_AF,
    RED_BF,
    RED_FLD
  } red_t;

  state_t                         state;
  red_t                           red;
  logic [rcoa_pkg::CNT_W-1:0]     cnt;
  logic [DW-1:0]                  r;
  logic [DW-1:0]                  src;
  logic                           op;
  logic [DW-1:0]                  a_raw;
  logic [DW-1:0]                  b_raw;
  logic [rcoa_pkg::MODE_W-1:0]    am;
  logic [rcoa_pkg::MODE_W-1:0]    bm;
  logic [DW-1:0]                  base;
  logic [DW-1:0]                  fa;
  logic [DW-1:0]                  fb;
  logic                           opnd;
  logic [DW-1:0]                  cell_addr;
  logic [DW-1:0]                  val;
  logic [DW-1:0]                  a_off;
  logic [DW-1:0]                  b_off;

  logic [rcoa_pkg::MODE_W-1:0]    cur_mode;
  logic [DW-1:0]                  cur_f;
  logic                           is_imm;
  logic                           is_dir;
  logic                           use_a;
  logic                           predec;
  logic                           postinc;
  logic [rcoa_pkg::CS_W-1:0]      add_x;
  logic [DW-1:0]                  add_y;
  logic [DW-1:0]                  sum;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cur_mode = opnd ? bm : am;
    cur_f    = opnd ? fb : fa;
    is_imm   = (cur_mode == rcoa_pkg::MODE_IMM);
    is_dir   = (cur_mode == rcoa_pkg::MODE_DIR);
    use_a    = (cur_mode == rcoa_pkg::MODE_AIND) || (cur_mode == rcoa_pkg::MODE_APRE) ||
               (cur_mode == rcoa_pkg::MODE_APOST);
    predec   = (cur_mode == rcoa_pkg::MODE_BPRE) || (cur_mode == rcoa_pkg::MODE_APRE);
    postinc  = (cur_mode == rcoa_pkg::MODE_BPOST) || (cur_mode == rcoa_pkg::MODE_APOST);
  end

  // operand select for the shared adder
  always_comb begin
    unique case (state)
      ST_MOD: begin
        add_x = {r, src[DW-1]};
        add_y = '0;
      end
      ST_CELL: begin
        add_x = {1'b0, base};
        add_y = cur_f;
      end
      ST_DEC: begin
        add_x = {1'b0, val};
        add_y = DW'(cs - rcoa_pkg::CS_W'(1));
      end
      ST_OFFS: begin
        add_x = {1'b0, cur_f};
        add_y = val;
      end
      ST_INC: begin
        add_x = {1'b0, val};
        add_y = DW'(1);
      end
      default: begin
        add_x = '0;
        add_y = '0;
      end
    endcase
  end

  rcoa_modadd u_modadd (
    .x   (add_x),
    .y   (add_y),
    .cs  (cs),
    .sum (sum)
  );

  always_comb begin
    core_req.addr    = cell_addr;
    core_req.we_a    = 1'b0;
    core_req.we_b    = 1'b0;
    core_req.wdata_a = sum;
    core_req.wdata_b = sum;
    if (state == ST_CELL) begin
      core_req.addr = sum;
    end else if (state == ST_WRITE) begin
      core_req.addr    = base;
      core_req.we_a    = 1'b1;
      core_req.we_b    = 1'b1;
      core_req.wdata_a = fa;
      core_req.wdata_b = fb;
    end else if (state == ST_DEC || state == ST_INC) begin
      core_req.we_a = use_a;
      core_req.we_b = !use_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op    <= in_op;
            a_raw <= in_data[rcoa_pkg::IN_AF_LSB +: DW];
            b_raw <= in_data[rcoa_pkg::IN_BF_LSB +: DW];
            am    <= in_data[rcoa_pkg::IN_AM_LSB +: rcoa_pkg::MODE_W];
            bm    <= in_data[rcoa_pkg::IN_BM_LSB +: rcoa_pkg::MODE_W];
            src   <= (in_op == rcoa_pkg::OP_LOAD) ? in_data[rcoa_pkg::IN_ADDR_LSB +: DW]
                                                  : in_data[rcoa_pkg::IN_PC_LSB +: DW];
            r     <= '0;
            cnt   <= '0;
            red   <= RED_FIRST;
            opnd  <= 1'b0;
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          r   <= sum;
          src <= {src[DW-2:0], 1'b0};
          cnt <= cnt + rcoa_pkg::CNT_W'(1);
          if (cnt == rcoa_pkg::CNT_LAST) begin
            cnt <= '0;
            r   <= '0;
            unique case (red)
              RED_FIRST: begin
                base <= sum;
                src  <= a_raw;
                red  <= RED_AF;
              end
              RED_AF: begin
                fa  <= sum;
                src <= b_raw;
                red <= RED_BF;
              end
              RED_BF: begin
                fb    <= sum;
                state <= (op == rcoa_pkg::OP_LOAD) ? ST_WRITE : ST_CELL;
              end
              RED_FLD: begin
                val   <= sum;
                state <= predec ? ST_DEC : ST_OFFS;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_CELL: begin
          if (is_imm || is_dir) begin
            if (opnd) begin
              b_off <= is_imm ? '0 : cur_f;
              state <= ST_DONE;
            end else begin
              a_off <= is_imm ? '0 : cur_f;
              opnd  <= 1'b1;
            end
          end else begin
            cell_addr <= sum;
            state     <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          src   <= use_a ? core_rsp.a : core_rsp.b;
          r     <= '0;
          cnt   <= '0;
          red   <= RED_FLD;
          state <= ST_MOD;
        end
        ST_DEC: begin
          val   <= sum;
          state <= ST_OFFS;
        end
        ST_OFFS: begin
          if (opnd) begin
            b_off <= sum;
          end else begin
            a_off <= sum;
          end
          if (postinc) begin
            state <= ST_INC;
          end else if (opnd) begin
            state <= ST_DONE;
          end else begin
            opnd  <= 1'b1;
            state <= ST_CELL;
          end
        end
        ST_INC: begin
          if (opnd) begin
            state <= ST_DONE;
          end else begin
            opnd  <= 1'b1;
            state <= ST_CELL;
          end
        end
        ST_WRITE: begin
          state <= ST_IDLE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= {{rcoa_pkg::OUT_PAD_W{1'b0}}, b_off, b_off, a_off, a_off};
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= rcoa_pkg::CNT_LAST)
    else $error("remainder step counter out of range");

  a_wr_states: assert property (@(posedge clk) disable iff (rst)
    (core_req.we_a || core_req.we_b) |->
      (state == ST_DEC || state == ST_INC || state == ST_WRITE))
    else $error("core write outside a write state");

  a_single_field: assert property (@(posedge clk) disable iff (rst)
    (state != ST_WRITE) |-> !(core_req.we_a && core_req.we_b))
    else $error("operand update wrote both fields");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the done step");

endmodule

`default_nettype wire

[hdl/redcode_operand_address_eval.sv]
`default_nettype none

// Redcode operand address evaluator. A transfer with tuser = 0 loads one core cell (A and B
// fields); a transfer with tuser = 1 evaluates an instruction's A then B operand in the
// immediate, direct, indirect, predecrement and postincrement modes, updating core cells
// as the modes require, and returns one result of four PC-relative offsets reduced modulo
// the core size (read and write offsets of an operand are equal). All arithmetic runs
// through one modular adder under a sequencer; every reduction of a 13-bit value modulo the
// core size takes one remainder bit per cycle. A load reduces the cell address and both
// fields and writes the cell; an evaluate reduces the PC and both fields, and each indirect
// operand adds a core read, a reduction of the fetched field and, for a predecrement or a
// postincrement, a core update. s_axis_tready is low while an item is in work. The core
// cells live in one single-port memory, so the up to two read-modify-write updates per
// item are serialized. A finished result waits in the output register while the next item
// is accepted; an evaluate holds in its last step while the previous result is still
// untaken. The core size register is written with cfg_wr_en while the block is idle, a
// rule for the user that the block itself does not enforce; values below 2 act as 2 and
// values above 8192 as 8192. Cells read before they are loaded return undefined fields.
module redcode_operand_address_eval (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [rcoa_pkg::CS_W-1:0]             cfg_wr_data,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // cell_address, program_counter, a_field_in, b_field_in, a_mode, b_mode (low bit up)
  input  wire logic [rcoa_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // opcode
  input  wire logic                                  s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // a_read_offset, a_write_offset, b_read_offset, b_write_offset (low bit up)
  output logic      [rcoa_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  logic [rcoa_pkg::CS_W-1:0] cs;
  logic [rcoa_pkg::CS_W-1:0] cs_next;
  rcoa_pkg::core_req_t       core_req;
  rcoa_pkg::core_rsp_t       core_rsp;

  // Clamp the written core size once, so the datapath always sees a legal modulus.
  always_comb begin
    priority if (cfg_wr_data < rcoa_pkg::CS_MIN) begin
      cs_next = rcoa_pkg::CS_MIN;
    end else if (cfg_wr_data > rcoa_pkg::CS_MAX) begin
      cs_next = rcoa_pkg::CS_MAX;
    end else begin
      cs_next = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cs <= rcoa_pkg::CS_RESET;
    end else if (cfg_wr_en) begin
      cs <= cs_next;
    end
  end

  // Sequencer with the shared modular adder.
  rcoa_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cs        (cs),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_op     (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .core_req  (core_req),
    .core_rsp  (core_rsp)
  );

  // Core A and B field memory.
  rcoa_core u_core (
    .clk (clk),
    .req (core_req),
    .rsp (core_rsp)
  );

endmodule

`default_nettype wire
